>>> design/tcpq_pkg.sv
// Shared types, sizes and status codes of the two-class push-out queue.
// Used by tcpq_adder, tcpq_ctrl and the top level; depends on nothing.
package tcpq_pkg;

    localparam int PORTS       = 4;
    localparam int QUEUE_DEPTH = 64;
    localparam int HANDLE_BITS = 16;
    localparam int STAMP_W     = 32;
    localparam int LIMIT_W     = 7;
    localparam int STATUS_W    = 3;
    localparam int PORT_W      = $clog2(PORTS);
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;
    localparam int ADDR_W      = PORT_W + PTR_W;
    localparam int ENTRY_W     = STAMP_W + HANDLE_BITS;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DISPLACED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SENT      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_SEND    = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic busy;
        logic exec;
    } ctrl_t;

endpackage

>>> design/tcpq_ram.sv
// Generic simple dual-port RAM with a registered read port.
// Holds one class's queue entries for all ports; no package dependencies.
module tcpq_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/tcpq_adder.sv
// Shared stamp adder: advances arrival stamps and compares head stamps.
// Depends on tcpq_pkg for the stamp width.
module tcpq_adder (
    input  logic [tcpq_pkg::STAMP_W-1:0] a,
    input  logic [tcpq_pkg::STAMP_W-1:0] b,
    input  logic                         negate,
    output logic [tcpq_pkg::STAMP_W-1:0] sum
);
    import tcpq_pkg::*;

    // The carry-in is always set: a + b + 1 for an increment with b at zero,
    // a - b when b is inverted.
    assign sum = a + (negate ? ~b : b) + STAMP_W'(1);

endmodule

>>> design/tcpq_ctrl.sv
// Sequencer of the queue: an accept cycle that reads the stores, then the
// execute cycle. Depends on tcpq_pkg for the state and control types.
module tcpq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output tcpq_pkg::ctrl_t ctrl
);
    import tcpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                ctrl.busy = 1'b0;
                ctrl.exec = 1'b0;
            end
            S_EXEC:
            begin
                ctrl.busy = 1'b1;
                ctrl.exec = 1'b1;
            end
            default:
            begin
                ctrl.busy = 1'b1;
                ctrl.exec = 1'b0;
            end
        endcase
    end

endmodule

>>> design/two_class_pushout_queue.sv
// Top level of the two-class push-out queue: per-port pointers, the two
// entry stores, the shared stamp adder and the result register.
// Depends on tcpq_pkg, tcpq_ctrl, tcpq_adder and tcpq_ram.

// A command is taken when start is high and busy is low. In the accept
// cycle both stores are read at the addressed port's head entries (or the
// secondary tail for an enqueue), and in the following execute cycle the
// shared 32-bit adder compares the head stamps or advances the arrival stamp
// while pointers and stores are updated. The result appears for exactly one
// cycle, flagged by done, in the cycle after execute; start may be taken in
// that same cycle, but not during execute. The receiver cannot stall results.
// The user must write the capacity limit through limit_we and limit_wdata
// only while the block is idle; the block does not enforce this. Values
// above the queue depth act as the depth.
module two_class_pushout_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [tcpq_pkg::PORT_W-1:0]       port,
    input  logic                              item_class,
    input  logic [tcpq_pkg::HANDLE_BITS-1:0]  handle,
    input  logic                              limit_we,
    input  logic [tcpq_pkg::LIMIT_W-1:0]      limit_wdata,
    output logic                              done,
    output logic [tcpq_pkg::STATUS_W-1:0]     status,
    output logic [tcpq_pkg::HANDLE_BITS-1:0]  out_handle,
    output logic                              out_class,
    output logic [tcpq_pkg::LIMIT_W-1:0]      occupancy
);
    import tcpq_pkg::*;

    ctrl_t ctrl;
    logic  accept;

    logic [LIMIT_W-1:0] limit_reg;

    logic [PTR_W-1:0]   phead_reg  [PORTS];
    logic [PTR_W-1:0]   shead_reg  [PORTS];
    logic [CNT_W-1:0]   pcount_reg [PORTS];
    logic [CNT_W-1:0]   scount_reg [PORTS];
    logic [STAMP_W-1:0] arr_reg    [PORTS];

    logic                   cmd_reg;
    logic [PORT_W-1:0]      port_reg;
    logic                   class_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    logic                   done_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [HANDLE_BITS-1:0] ohandle_reg;
    logic                   oclass_reg;
    logic [LIMIT_W-1:0]     occ_reg;

    // Store ports.
    logic [ADDR_W-1:0]  p_raddr, s_raddr, p_waddr, s_waddr;
    logic [ENTRY_W-1:0] p_rdata, s_rdata, wdata;
    logic               p_we, s_we;

    // Execute-cycle values.
    logic [PTR_W-1:0]       ph, sh, ph_next, sh_next;
    logic [CNT_W-1:0]       pc, sc, pc_next, sc_next, total;
    logic [LIMIT_W-1:0]     lim;
    logic [STAMP_W-1:0]     add_a, add_b, add_sum, arr_next;
    logic                   port_ok;
    logic                   take_primary;
    logic [STATUS_W-1:0]    status_next;
    logic [HANDLE_BITS-1:0] ohandle_next;
    logic                   oclass_next;
    logic [CNT_W-1:0]       occ_next;

    tcpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .ctrl  (ctrl)
    );

    assign busy   = ctrl.busy;
    assign accept = start && !ctrl.busy;

    // Read addresses come straight from the command so the entries are
    // registered at the accept edge.
    always_comb
    begin
        p_raddr = {port, phead_reg[port]};
        if (cmd == CMD_SEND)
        begin
            s_raddr = {port, shead_reg[port]};
        end
        else
        begin
            s_raddr = {port, shead_reg[port] + scount_reg[port][PTR_W-1:0] - PTR_W'(1)};
        end
    end

    tcpq_ram #(.ADDR_W(ADDR_W), .DATA_W(ENTRY_W)) u_pstore (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (wdata),
        .re    (accept),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    tcpq_ram #(.ADDR_W(ADDR_W), .DATA_W(ENTRY_W)) u_sstore (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (wdata),
        .re    (accept),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign ph      = phead_reg[port_reg];
    assign sh      = shead_reg[port_reg];
    assign pc      = pcount_reg[port_reg];
    assign sc      = scount_reg[port_reg];
    assign total   = pc + sc;
    assign lim     = (limit_reg > LIMIT_W'(QUEUE_DEPTH)) ? LIMIT_W'(QUEUE_DEPTH) : limit_reg;
    assign port_ok = int'(port_reg) < PORTS;

    assign add_a = (cmd_reg == CMD_SEND) ? p_rdata[ENTRY_W-1 -: STAMP_W] : arr_reg[port_reg];
    assign add_b = (cmd_reg == CMD_SEND) ? s_rdata[ENTRY_W-1 -: STAMP_W] : '0;

    tcpq_adder u_adder (
        .a      (add_a),
        .b      (add_b),
        .negate (cmd_reg == CMD_SEND),
        .sum    (add_sum)
    );

    assign wdata   = {arr_reg[port_reg], handle_reg};
    assign p_waddr = {port_reg, ph + pc[PTR_W-1:0]};
    assign s_waddr = {port_reg, sh + sc[PTR_W-1:0]};

    always_comb
    begin
        ph_next      = ph;
        sh_next      = sh;
        pc_next      = pc;
        sc_next      = sc;
        arr_next     = arr_reg[port_reg];
        p_we         = 1'b0;
        s_we         = 1'b0;
        take_primary = 1'b0;
        status_next  = ST_REJECTED;
        ohandle_next = '0;
        oclass_next  = 1'b0;

        if (!port_ok)
        begin
            if (cmd_reg == CMD_ENQUEUE)
            begin
                ohandle_next = handle_reg;
                oclass_next  = class_reg;
            end
            else
            begin
                status_next = ST_EMPTY;
            end
        end
        else if (cmd_reg == CMD_ENQUEUE)
        begin
            if (total < CNT_W'(lim))
            begin
                status_next = ST_QUEUED;
                arr_next    = add_sum;
                if (class_reg)
                begin
                    p_we    = ctrl.exec;
                    pc_next = pc + CNT_W'(1);
                end
                else
                begin
                    s_we    = ctrl.exec;
                    sc_next = sc + CNT_W'(1);
                end
            end
            else if (class_reg && (sc != '0))
            begin
                // The newest secondary entry gives its place to the primary one.
                status_next  = ST_DISPLACED;
                ohandle_next = s_rdata[HANDLE_BITS-1:0];
                sc_next      = sc - CNT_W'(1);
                p_we         = ctrl.exec;
                pc_next      = pc + CNT_W'(1);
                arr_next     = add_sum;
            end
            else
            begin
                ohandle_next = handle_reg;
                oclass_next  = class_reg;
            end
        end
        else
        begin
            if ((pc == '0) && (sc == '0))
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                // With both classes waiting the older stamp wins; equal stamps go
                // to the secondary head.
                if ((pc != '0) && (sc != '0))
                begin
                    take_primary = add_sum[STAMP_W-1];
                end
                else
                begin
                    take_primary = (pc != '0);
                end
                status_next = ST_SENT;
                if (take_primary)
                begin
                    ohandle_next = p_rdata[HANDLE_BITS-1:0];
                    oclass_next  = 1'b1;
                    ph_next      = ph + PTR_W'(1);
                    pc_next      = pc - CNT_W'(1);
                end
                else
                begin
                    ohandle_next = s_rdata[HANDLE_BITS-1:0];
                    sh_next      = sh + PTR_W'(1);
                    sc_next      = sc - CNT_W'(1);
                end
            end
        end

        occ_next = port_ok ? (pc_next + sc_next) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (limit_we)
        begin
            limit_reg <= limit_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            port_reg   <= port;
            class_reg  <= item_class;
            handle_reg <= handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                phead_reg[i]  <= '0;
                shead_reg[i]  <= '0;
                pcount_reg[i] <= '0;
                scount_reg[i] <= '0;
                arr_reg[i]    <= '0;
            end
        end
        else if (ctrl.exec && port_ok)
        begin
            phead_reg[port_reg]  <= ph_next;
            shead_reg[port_reg]  <= sh_next;
            pcount_reg[port_reg] <= pc_next;
            scount_reg[port_reg] <= sc_next;
            arr_reg[port_reg]    <= arr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            status_reg  <= status_next;
            ohandle_reg <= ohandle_next;
            oclass_reg  <= oclass_next;
            occ_reg     <= LIMIT_W'(occ_next);
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign out_handle = ohandle_reg;
    assign out_class  = oclass_reg;
    assign occupancy  = occ_reg;

    // Every execute cycle delivers exactly one result beat in the next cycle.
    a_exec_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec |=> done)
        else $error("execute cycle without a result beat");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctrl.exec))
        else $error("result beat without an execute cycle");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (occupancy <= LIMIT_W'(QUEUE_DEPTH)))
        else $error("occupancy above queue depth");

    a_no_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (p_we || s_we) |-> ctrl.exec)
        else $error("store written outside an execute cycle");

endmodule
